// File: rtl/firi_pkg.sv
// ----------------------------------------------------------------------------
// firi_pkg: shared types, constants and ROMs of the interleaved FIR core
// Holds the sample and coefficient types, the coefficient table, the control
// word format and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package firi_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 40;
   localparam int CSR_W    = 2;
   localparam int FRAC_SHIFT = 17;
   localparam int RES_W    = ACC_W - FRAC_SHIFT;

   localparam int TAPS_DEF          = 51;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int MAX_CHANNELS_DEF  = 2;

   localparam int COEF_IDX_W = 6;
   localparam int HALF_COEFS = 26;
   localparam int CENTER_SUM = 2 * (HALF_COEFS - 1);

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // first half of the symmetric low-pass response, Q1.17
   localparam coef_type HALF_COEF [HALF_COEFS] = '{
      -18'sd138,   -18'sd876,   -18'sd2012, -18'sd1977, -18'sd34,
       18'sd1389,   18'sd77,    -18'sd1391,  18'sd106,   18'sd1614,
      -18'sd412,   -18'sd1940,   18'sd882,   18'sd2317, -18'sd1590,
      -18'sd2713,   18'sd2652,   18'sd3097, -18'sd4290, -18'sd3436,
       18'sd7078,   18'sd3702,  -18'sd13116, -18'sd3871, 18'sd41454,
       18'sd69467
   };

   // mirror the tap index onto the stored half
   function automatic coef_type coef_at(input logic [COEF_IDX_W-1:0] k);
      logic [COEF_IDX_W-1:0] m;
      m = k;
      if (k >= COEF_IDX_W'(HALF_COEFS)) begin
         if (COEF_IDX_W'(CENTER_SUM) >= k) begin
            m = COEF_IDX_W'(CENTER_SUM) - k;
         end else begin
            m = '0;
         end
      end
      if (m >= COEF_IDX_W'(HALF_COEFS)) begin
         m = '0;
      end
      return HALF_COEF[m[4:0]];
   endfunction

   // microcode
   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_SETUP  = 3'd1;
   localparam step_type STEP_MAC    = 3'd2;
   localparam step_type STEP_DRAIN0 = 3'd3;
   localparam step_type STEP_DRAIN1 = 3'd4;
   localparam step_type STEP_FINISH = 3'd5;
   localparam step_type STEP_RETURN = 3'd6;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_BEAT,
      COND_COLD,
      COND_MORE_TAPS,
      COND_RSP_BUSY,
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      logic     rdy;     // take a request beat
      logic     clr;     // clear accumulator, rewind tap counter
      logic     issue;   // issue one history read and coefficient fetch
      logic     fin;     // round, load response, advance frame state
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic beat;
      logic cold;
      logic more_taps;
      logic rsp_busy;
   } status_type;

   function automatic ucode_type ucode_rom(input step_type pc);
      ucode_type w;
      w = '{rdy: 1'b0, clr: 1'b0, issue: 1'b0, fin: 1'b0,
            cond: COND_NEVER, target: STEP_WAIT};
      case (pc)
         STEP_WAIT: begin
            w.rdy    = 1'b1;
            w.cond   = COND_NO_BEAT;
            w.target = STEP_WAIT;
         end
         STEP_SETUP: begin
            w.clr    = 1'b1;
            w.cond   = COND_COLD;
            w.target = STEP_FINISH;
         end
         STEP_MAC: begin
            w.issue  = 1'b1;
            w.cond   = COND_MORE_TAPS;
            w.target = STEP_MAC;
         end
         STEP_DRAIN0: begin
            w.cond   = COND_NEVER;
         end
         STEP_DRAIN1: begin
            w.cond   = COND_NEVER;
         end
         STEP_FINISH: begin
            w.fin    = 1'b1;
            w.cond   = COND_RSP_BUSY;
            w.target = STEP_FINISH;
         end
         STEP_RETURN: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/firi_if.sv
// ----------------------------------------------------------------------------
// firi_if: request and response channels of the interleaved FIR core
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface firi_req_if;
   logic                 valid;
   logic                 ready;
   firi_pkg::sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface firi_rsp_if;
   logic                 valid;
   logic                 ready;
   firi_pkg::sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/firi_ram.sv
// ----------------------------------------------------------------------------
// firi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module firi_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/firi_sequencer.sv
// ----------------------------------------------------------------------------
// firi_sequencer: microcode step counter of the interleaved FIR core
// Fetches one control word per step and jumps on the selected condition.
// ----------------------------------------------------------------------------
module firi_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  firi_pkg::status_type status,
   output firi_pkg::ucode_type  ctrl
);
   import firi_pkg::*;

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      jump;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:     jump = 1'b0;
         COND_NO_BEAT:   jump = !status.beat;
         COND_COLD:      jump = status.cold;
         COND_MORE_TAPS: jump = status.more_taps;
         COND_RSP_BUSY:  jump = status.rsp_busy;
         COND_ALWAYS:    jump = 1'b1;
         default:        jump = 1'b1;
      endcase
      pc_in = jump ? word.target : pc_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = word;

endmodule

// File: rtl/fir_filter_interleaved_core.sv
// ----------------------------------------------------------------------------
// fir_filter_interleaved_core: 51-tap symmetric low-pass FIR, interleaved
// Microcoded FIR over one or two interleaved audio channels with one MAC.
// ----------------------------------------------------------------------------
// Each request beat carries one Q1.15 sample of the current channel; the core
// stores it in that channel's circular history and returns one response beat:
// the sum of TAPS fixed Q1.17 coefficients times the newest TAPS samples of
// the channel, rounded half up and saturated to Q1.15, or zero until TAPS
// whole frames have gone by. One item walks all TAPS taps through the
// single multiply-accumulate unit, which reads one history entry per cycle
// from the one read port of the history RAM; a warm-up item skips the walk.
// A finished result waits in the response register, and the core takes the
// next request while it waits; it stalls only when a second result is ready
// before the first has been taken. Write csr_wdata with csr_we to set the
// channel count (0 acts as 1, above MAX_CHANNELS acts as MAX_CHANNELS); a
// write restarts the frame at channel 0 and keeps the history and warm-up
// count. Write only while the core is idle. The history has no clearing pass:
// an entry of a channel not yet in use can be read before it was written.
// ----------------------------------------------------------------------------
module fir_filter_interleaved_core #(
   parameter int TAPS          = firi_pkg::TAPS_DEF,
   parameter int HISTORY_DEPTH = firi_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_CHANNELS  = firi_pkg::MAX_CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   firi_req_if.sink                    req_if,
   firi_rsp_if.source                  rsp_if,
   input  logic                        csr_we,
   input  logic [firi_pkg::CSR_W-1:0]  csr_wdata
);
   import firi_pkg::*;

   localparam int RAM_DEPTH = MAX_CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
   localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FR_W      = $clog2(TAPS + 1);
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_RAW_W = $clog2(MAX_CHANNELS + 1);
   localparam int NCH_W     = (CNT_RAW_W > CSR_W) ? CNT_RAW_W : CSR_W;

   // control
   ucode_type  ctrl;
   status_type status;
   logic       beat;
   logic       fin_go;
   logic       rsp_busy;

   // frame state
   logic [CSR_W-1:0]  csr_ff;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FR_W-1:0]   frames_ff, frames_in;

   // datapath
   logic [TAP_W-1:0]         tap_ff, tap_in;
   logic [SLOT_W-1:0]        rdptr_ff, rdptr_in;
   coef_type                 coef_ff;
   logic                     rd_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sample_type               rsp_data_ff;

   logic [NCH_W-1:0]        nch;
   logic [NCH_W-1:0]        ch_ext;
   logic [NCH_W-1:0]        ch_eff;
   logic [NCH_W-1:0]        ch_next;
   logic [ADDR_W-1:0]       base_addr;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;
   logic [SAMPLE_W-1:0]     rd_data;
   logic signed [ACC_W-1:0] rounded_sum;
   logic signed [RES_W-1:0] scaled;
   sample_type              result;

   firi_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign beat     = ctrl.rdy && req_if.valid;
   assign rsp_busy = rsp_valid_ff && !rsp_if.ready;
   assign fin_go   = ctrl.fin && !rsp_busy;

   assign status.beat      = beat;
   assign status.cold      = (frames_ff != FR_W'(TAPS));
   assign status.more_taps = (tap_ff != TAP_W'(TAPS - 1));
   assign status.rsp_busy  = rsp_busy;

   // clamp the channel count and the current channel
   always_comb begin
      ch_ext = NCH_W'(ch_ff);
      if (csr_ff == '0) begin
         nch = NCH_W'(1);
      end else if (NCH_W'(csr_ff) > NCH_W'(MAX_CHANNELS)) begin
         nch = NCH_W'(MAX_CHANNELS);
      end else begin
         nch = NCH_W'(csr_ff);
      end
      ch_eff  = (ch_ext >= nch) ? '0 : ch_ext;
      ch_next = ch_eff + NCH_W'(1);
   end

   assign base_addr = ADDR_W'(ADDR_W'(ch_eff) * ADDR_W'(HISTORY_DEPTH));
   assign wr_addr   = base_addr + ADDR_W'(slot_ff);
   assign rd_addr   = base_addr + ADDR_W'(rdptr_ff);

   firi_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (beat),
      .wr_addr (wr_addr),
      .wr_data (req_if.sample_in),
      .rd_en   (ctrl.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // round half up, drop the Q1.17 scale, saturate to 16 bits
   always_comb begin
      rounded_sum = acc_ff + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
      scaled      = RES_W'(rounded_sum >>> FRAC_SHIFT);
      if (scaled > RES_W'(32767)) begin
         result = 16'sh7FFF;
      end else if (scaled < -RES_W'(32768)) begin
         result = 16'sh8000;
      end else begin
         result = SAMPLE_W'(scaled);
      end
   end

   // tap walk, accumulator and response
   always_comb begin
      tap_in   = tap_ff;
      rdptr_in = rdptr_ff;
      acc_in   = acc_ff;
      if (ctrl.clr) begin
         tap_in   = '0;
         rdptr_in = slot_ff;
         acc_in   = '0;
      end else begin
         if (ctrl.issue) begin
            tap_in   = tap_ff + TAP_W'(1);
            // step back one slot, wrap below zero
            rdptr_in = (rdptr_ff == '0) ? SLOT_W'(HISTORY_DEPTH - 1)
                                        : rdptr_ff - SLOT_W'(1);
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   // advance the channel after each item, slot and warm-up count after each frame
   always_comb begin
      ch_in     = ch_ff;
      slot_in   = slot_ff;
      frames_in = frames_ff;
      if (csr_we) begin
         ch_in = '0;
      end else if (fin_go) begin
         if (ch_next >= nch) begin
            ch_in     = '0;
            slot_in   = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : slot_ff + SLOT_W'(1);
            frames_in = (frames_ff == FR_W'(TAPS)) ? frames_ff
                                                   : frames_ff + FR_W'(1);
         end else begin
            ch_in = CH_W'(ch_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         ch_ff        <= '0;
         slot_ff      <= '0;
         frames_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         ch_ff        <= ch_in;
         slot_ff      <= slot_in;
         frames_ff    <= frames_in;
         rd_vld_ff    <= ctrl.issue;
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      tap_ff   <= tap_in;
      rdptr_ff <= rdptr_in;
      acc_ff   <= acc_in;
      coef_ff  <= coef_at(COEF_IDX_W'(tap_ff));
      prod_ff  <= $signed(rd_data) * coef_ff;
      if (fin_go) begin
         rsp_data_ff <= result;
      end
   end

   assign req_if.ready      = ctrl.rdy;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

   // checks
   a_one_beat_per_item: assert property (@(posedge clock) disable iff (reset)
      beat |=> !ctrl.rdy)
      else $error("request beat taken while an item is in flight");

   a_frames_saturate: assert property (@(posedge clock) disable iff (reset)
      frames_ff <= FR_W'(TAPS))
      else $error("warm-up count ran past the tap count");

   a_drained_at_finish: assert property (@(posedge clock) disable iff (reset)
      ctrl.fin |-> (!rd_vld_ff && !prod_vld_ff && !ctrl.issue))
      else $error("MAC pipeline not drained when the result is taken");

   a_cold_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (fin_go && status.cold) |=> (rsp_if.sample_out == '0))
      else $error("nonzero result during warm-up");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_if.sample_out)))
      else $error("pending response overwritten");

endmodule

// File: tb/sv/fir_filter_interleaved_core_tb.sv
// ----------------------------------------------------------------------------
// fir_filter_interleaved_core_tb: self-checking bench of the interleaved FIR
// Streams interleaved samples through the core under random back-pressure,
// predicts every filtered sample with a local 51-tap model, and compares each
// response beat in order. The channel count is changed between phases.
// ----------------------------------------------------------------------------
module fir_filter_interleaved_core_tb;
   import firi_pkg::*;

   localparam int TAP_COUNT    = 51;
   localparam int SLOT_COUNT   = 64;
   localparam int STALL_LIMIT  = 4000;  // cycles without any beat
   localparam int SETTLE_CYCLES = 8;    // quiet time before a channel-count write
   localparam int TAIL_CYCLES  = 100;   // watch for stray responses at the end
   localparam int REPORT_CAP   = 50;

   // channel-count register values; zero and three map to one and two
   localparam logic [CSR_W-1:0] CHANS_ZERO  = 2'd0;
   localparam logic [CSR_W-1:0] CHANS_ONE   = 2'd1;
   localparam logic [CSR_W-1:0] CHANS_TWO   = 2'd2;
   localparam logic [CSR_W-1:0] CHANS_THREE = 2'd3;

   // the first setting must be two channels so that channel 1 fills its
   // whole history before any single-channel phase leaves gaps in it
   localparam logic [CSR_W-1:0] CHAN_SCHEDULE [9] = '{
      CHANS_TWO, CHANS_THREE, CHANS_ONE, CHANS_ZERO, CHANS_TWO,
      CHANS_THREE, CHANS_ONE, CHANS_TWO, CHANS_ZERO
   };

   // warm-up stimulus: full-scale corners, sign boundaries, bit patterns
   localparam sample_type WARMUP_SAMPLES [24] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'shFFFE,
      16'sh4000, 16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFE, 16'sh8001,
      16'sh00FF, 16'shFF00, 16'sh0F0F, 16'shF0F0, 16'sh3333, 16'shCCCC,
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000
   };

   // first half of the symmetric low-pass response, Q1.17
   localparam logic signed [17:0] LOWPASS_HALF [26] = '{
      -18'sd138,   -18'sd876,   -18'sd2012, -18'sd1977, -18'sd34,
       18'sd1389,   18'sd77,    -18'sd1391,  18'sd106,   18'sd1614,
      -18'sd412,   -18'sd1940,   18'sd882,   18'sd2317, -18'sd1590,
      -18'sd2713,   18'sd2652,   18'sd3097, -18'sd4290, -18'sd3436,
       18'sd7078,   18'sd3702,  -18'sd13116, -18'sd3871, 18'sd41454,
       18'sd69467
   };

   typedef enum int {
      PAT_NOISE,        // full-range random
      PAT_MATCHED,      // sign follows the taps: positive saturation on lane 0, negative on lane 1
      PAT_MATCHED_NEG,  // sign against the taps: negative saturation on lane 0, positive on lane 1
      PAT_FULL_SCALE,   // DC at either rail
      PAT_QUIET,        // small random values
      PAT_NYQUIST,      // alternating rails
      PAT_IMPULSE,      // one random spike per tap window
      PAT_COUNT
   } sample_pattern_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_W-1:0] csr_wdata;

   firi_req_if req_bus ();
   firi_rsp_if rsp_bus ();

   fir_filter_interleaved_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   sample_type samples_to_send [$];
   sample_type filtered_due [$];
   int         mismatch_count = 0;
   int         quiet_cycles   = 0;
   int         samples_sent   = 0;
   bit         req_took       = 1'b0;
   bit         drain_hold     = 1'b0;

   // local copy of the filter state
   sample_type       tap_history [2][SLOT_COUNT];
   logic [5:0]       frame_slot;
   logic [5:0]       frames_filled;
   logic             chan_now;
   logic [CSR_W-1:0] chan_cfg;

   // ------------------------------------------------------------------------
   // clock and power-on values
   // ------------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = CSR_RESET;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready     = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int active_lanes(logic [CSR_W-1:0] cfg);
      if (cfg == CHANS_ZERO) begin
         return 1;
      end
      if (cfg > CHANS_TWO) begin
         return 2;
      end
      return int'(cfg);
   endfunction

   // mirror taps 26..50 onto the stored half
   function automatic logic signed [17:0] tap_weight(int k);
      return (k < 26) ? LOWPASS_HALF[k] : LOWPASS_HALF[2 * 25 - k];
   endfunction

   // store one sample, return the filtered sample it produces, advance frame
   function automatic sample_type filter_step(sample_type s);
      int                lanes;
      logic signed [39:0] sum;
      logic signed [39:0] scaled;
      logic [5:0]        rd_slot;
      sample_type        y;
      lanes = active_lanes(chan_cfg);
      if (int'(chan_now) >= lanes) begin
         chan_now = 1'b0;
      end
      tap_history[chan_now][frame_slot] = s;
      y = '0;
      if (frames_filled >= 6'(TAP_COUNT)) begin
         sum = '0;
         for (int j = 0; j < TAP_COUNT; j++) begin
            rd_slot = frame_slot - 6'(j);
            sum = sum + tap_weight(j) * tap_history[chan_now][rd_slot];
         end
         // round half up, then floor by the arithmetic shift
         scaled = (sum + 40'sd65536) >>> FRAC_SHIFT;
         if (scaled > 40'sd32767) begin
            y = 16'sh7FFF;
         end else if (scaled < -40'sd32768) begin
            y = 16'sh8000;
         end else begin
            y = scaled[15:0];
         end
      end
      if (int'(chan_now) + 1 >= lanes) begin
         chan_now   = 1'b0;
         frame_slot = frame_slot + 6'd1;
         if (frames_filled < 6'(TAP_COUNT)) begin
            frames_filled = frames_filled + 6'd1;
         end
      end else begin
         chan_now = 1'b1;
      end
      return y;
   endfunction

   task automatic report_mismatch(string what, sample_type want, sample_type got);
      if (mismatch_count < REPORT_CAP) begin
         $display("ERROR %s: expected %0d got %0d", what, want, got);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // monitor: sample both channels and the register port at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         frame_slot    = '0;
         frames_filled = '0;
         chan_now      = 1'b0;
         chan_cfg      = CSR_RESET;
         quiet_cycles  = 0;
      end else begin
         // a register write restarts the frame at channel 0
         if (csr_we) begin
            chan_cfg = csr_wdata;
            chan_now = 1'b0;
         end
         if (req_bus.valid && req_bus.ready) begin
            filtered_due.push_back(filter_step(req_bus.sample_in));
            req_took = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (filtered_due.size() == 0) begin
               report_mismatch("response beat with nothing due", '0, rsp_bus.sample_out);
            end else if (rsp_bus.sample_out !== filtered_due[0]) begin
               report_mismatch("sample_out", filtered_due[0], rsp_bus.sample_out);
               void'(filtered_due.pop_front());
            end else begin
               void'(filtered_due.pop_front());
            end
         end
         // watchdog: count cycles in which no beat moves on either channel
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL fir_filter_interleaved_core");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: change inputs at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      int  send_idle_pct;
      int  recv_idle_pct;
      bit  slot_free;
      // first third: sender idles less; second: the other way; then no idling
      send_idle_pct = (samples_sent < 620) ? 29 : (samples_sent < 1240) ? 53 : 0;
      recv_idle_pct = (samples_sent < 620) ? 53 : (samples_sent < 1240) ? 29 : 0;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         slot_free = !req_bus.valid || req_took;
         if (req_took) begin
            req_took = 1'b0;
            samples_sent++;
            // now and then hold off until every result is back
            if (samples_sent == 100 || $urandom_range(0, 199) == 0) begin
               drain_hold = 1'b1;
            end
         end
         if (slot_free) begin
            if (drain_hold && filtered_due.size() == 0) begin
               drain_hold = 1'b0;
            end
            if (!drain_hold && samples_to_send.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid     <= 1'b1;
               req_bus.sample_in <= samples_to_send.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic sample_type pattern_sample(sample_pattern_type kind, int pos, int lane);
      bit rail_high;
      case (kind)
         PAT_MATCHED, PAT_MATCHED_NEG: begin
            rail_high = (tap_weight(pos) >= 0) ^ (kind == PAT_MATCHED_NEG) ^ (lane == 1);
            return rail_high ? 16'sh7FFF : 16'sh8000;
         end
         PAT_FULL_SCALE: begin
            return (lane == 0) ? 16'sh7FFF : 16'sh8000;
         end
         PAT_QUIET: begin
            return sample_type'($urandom_range(0, 511) - 256);
         end
         PAT_NYQUIST: begin
            return (pos % 2 == 0) ? 16'sh7FFF : 16'sh8000;
         end
         PAT_IMPULSE: begin
            return (pos == 0) ? sample_type'($urandom) : 16'sh0000;
         end
         default: begin
            return sample_type'($urandom);
         end
      endcase
   endfunction

   // fill one phase; each tap window of every lane shares one pattern
   task automatic queue_phase_samples(int count, int lanes);
      sample_pattern_type kind;
      kind = PAT_NOISE;
      for (int i = 0; i < count; i++) begin
         if (i % (TAP_COUNT * lanes) == 0) begin
            kind = sample_pattern_type'($urandom_range(0, int'(PAT_COUNT) - 1));
         end
         samples_to_send.push_back(pattern_sample(kind, (i / lanes) % TAP_COUNT, i % lanes));
      end
   endtask

   task automatic write_chan_count(logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // wait until every sample is sent and every result is back, then settle
   task automatic wait_until_idle();
      while (samples_to_send.size() != 0 || req_bus.valid || filtered_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase_len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed warm-up: every result must come back zero
      write_chan_count(CHANS_TWO);
      foreach (WARMUP_SAMPLES[i]) begin
         samples_to_send.push_back(WARMUP_SAMPLES[i]);
      end
      wait_until_idle();

      // random phases, each under its own channel count
      foreach (CHAN_SCHEDULE[p]) begin
         write_chan_count(CHAN_SCHEDULE[p]);
         phase_len = $urandom_range(185, 225);
         queue_phase_samples(phase_len, active_lanes(CHAN_SCHEDULE[p]));
         wait_until_idle();
      end

      // any response beat in the tail is flagged by the monitor
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS fir_filter_interleaved_core");
      end else begin
         $display("FAIL fir_filter_interleaved_core");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/firi_pkg.sv
rtl/firi_if.sv
rtl/firi_ram.sv
rtl/firi_sequencer.sv
rtl/fir_filter_interleaved_core.sv
tb/sv/fir_filter_interleaved_core_tb.sv
